### rtl/core/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg: shared types and codes of the stop-and-wait ARQ sender
// Word layouts of both channels, the connection state record, command and
// packet codes, and the action chosen for each event.
// ----------------------------------------------------------------------------
`default_nettype none

package sawarq_pkg;

  // Event commands
  localparam logic [2:0] CMD_OPEN    = 3'd0;
  localparam logic [2:0] CMD_DATA    = 3'd1;
  localparam logic [2:0] CMD_RX      = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT = 3'd3;
  localparam logic [2:0] CMD_CLOSE   = 3'd4;
  localparam logic [2:0] CMD_RX_ERR  = 3'd5;

  // Packet kinds, shared by received flags and transmitted kind
  localparam logic [1:0] KIND_SYN = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_FIN = 2'd2;

  // Segment position marks
  localparam logic [1:0] MARK_BEGIN  = 2'd0;
  localparam logic [1:0] MARK_MIDDLE = 2'd1;
  localparam logic [1:0] MARK_END    = 2'd2;

  // Status codes
  localparam logic [2:0] ST_WAITING   = 3'd0;
  localparam logic [2:0] ST_CONNECTED = 3'd1;
  localparam logic [2:0] ST_SEG_ACKED = 3'd2;
  localparam logic [2:0] ST_CLOSED    = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_INIT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_LIM  = 2'd1;
  localparam logic [1:0] REG_SHRINK_FLOOR = 2'd2;

  localparam logic [15:0] INIT_TIMEOUT_RST = 16'd5;
  localparam logic [15:0] TIMEOUT_LIM_RST  = 16'd20000;
  localparam logic [15:0] SHRINK_FLOOR_RST = 16'd1024;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYN    = 3'd1,
    PH_CONN   = 3'd2,
    PH_SEG    = 3'd3,
    PH_FIN    = 3'd4,
    PH_CLOSED = 3'd5,
    PH_ABORT  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ACT_QUIET    = 3'd0,
    ACT_RESEND   = 3'd1,
    ACT_HS_ACK   = 3'd2,
    ACT_SEG_DONE = 3'd3,
    ACT_FIN_ACKS = 3'd4
  } act_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [10:0] seg_length;
    logic        seg_last;
    logic [1:0]  rx_flags;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [1:0]  tx_kind;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [10:0] tx_length;
    logic [1:0]  tx_marker;
    logic [16:0] timeout_now;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] send_seq;
    logic [10:0] pend_len;
    logic [1:0]  pend_marker;
    logic        first_done;
    logic [16:0] timeout;
    logic [1:0]  pend_kind;
  } conn_state_t;

  typedef struct packed {
    logic [15:0] initial_timeout;
    logic [15:0] timeout_limit;
    logic [15:0] shrink_floor;
  } cfg_regs_t;

endpackage

`default_nettype wire

### rtl/core/sawarq_step.sv
// ----------------------------------------------------------------------------
// sawarq_step: event decoder of the ARQ sender
// Works out, for one event word and the present connection state, the next
// state, the packet word to send and how many extra copies of it follow.
// ----------------------------------------------------------------------------
`default_nettype none

module sawarq_step #(
  parameter int unsigned SEG_BYTES = 1024
) (
  input  wire sawarq_pkg::in_item_t    item,
  input  wire sawarq_pkg::conn_state_t st,
  input  wire sawarq_pkg::cfg_regs_t   cfg,
  output sawarq_pkg::conn_state_t      st_nxt,
  output sawarq_pkg::out_item_t        res,
  output logic [1:0]                   rep
);

  localparam int unsigned LEN_CMP_W = 17;

  sawarq_pkg::act_t act;
  logic        waiting;
  logic [10:0] len_sat;
  logic [31:0] seq_plus1;
  logic [31:0] seq_plus_len;
  logic [31:0] peer_ack;
  logic [16:0] tmo_dbl;
  logic [2:0]  quiet_status;

  assign waiting = (st.phase == sawarq_pkg::PH_SYN) || (st.phase == sawarq_pkg::PH_SEG) ||
                   (st.phase == sawarq_pkg::PH_FIN);
  assign len_sat = ({6'd0, item.seg_length} > LEN_CMP_W'(SEG_BYTES)) ?
                   11'(SEG_BYTES) : item.seg_length;
  assign seq_plus1    = st.send_seq + 32'd1;
  assign seq_plus_len = st.send_seq + {21'd0, st.pend_len} + 32'd1;
  assign peer_ack     = item.rx_seq + 32'd1;
  // A zero timeout stays zero, and the top bit falls off when doubled.
  assign tmo_dbl      = {st.timeout[15:0], 1'b0};

  // Next state and the action taken for the event.
  always_comb begin
    st_nxt = st;
    act    = sawarq_pkg::ACT_QUIET;
    case (item.cmd)
      sawarq_pkg::CMD_OPEN: begin
        if (st.phase == sawarq_pkg::PH_IDLE) begin
          st_nxt.send_seq    = 32'd0;
          st_nxt.pend_kind   = sawarq_pkg::KIND_SYN;
          st_nxt.pend_len    = 11'd0;
          st_nxt.pend_marker = sawarq_pkg::MARK_BEGIN;
          st_nxt.phase       = sawarq_pkg::PH_SYN;
          act                = sawarq_pkg::ACT_RESEND;
        end
      end
      sawarq_pkg::CMD_DATA: begin
        if (st.phase == sawarq_pkg::PH_CONN) begin
          if (!st.first_done) begin
            st_nxt.send_seq = 32'd0;
          end
          // An end mark wins over a begin mark on a one-segment file.
          st_nxt.pend_marker = item.seg_last ? sawarq_pkg::MARK_END :
                               (st.first_done ? sawarq_pkg::MARK_MIDDLE :
                                sawarq_pkg::MARK_BEGIN);
          st_nxt.first_done  = 1'b1;
          st_nxt.pend_len    = len_sat;
          st_nxt.pend_kind   = sawarq_pkg::KIND_ACK;
          st_nxt.phase       = sawarq_pkg::PH_SEG;
          act                = sawarq_pkg::ACT_RESEND;
        end
      end
      sawarq_pkg::CMD_CLOSE: begin
        if (st.phase == sawarq_pkg::PH_CONN) begin
          st_nxt.send_seq    = 32'd0;
          st_nxt.pend_kind   = sawarq_pkg::KIND_FIN;
          st_nxt.pend_len    = 11'd0;
          st_nxt.pend_marker = sawarq_pkg::MARK_BEGIN;
          st_nxt.phase       = sawarq_pkg::PH_FIN;
          act                = sawarq_pkg::ACT_RESEND;
        end
      end
      sawarq_pkg::CMD_RX: begin
        if (waiting) begin
          if (st.timeout >= {1'b0, cfg.shrink_floor}) begin
            st_nxt.timeout = {1'b0, st.timeout[16:1]};
          end
          if (st.phase == sawarq_pkg::PH_SYN) begin
            if (item.rx_ack == seq_plus1) begin
              st_nxt.send_seq = seq_plus1;
              st_nxt.phase    = sawarq_pkg::PH_CONN;
              act             = sawarq_pkg::ACT_HS_ACK;
            end else begin
              act = sawarq_pkg::ACT_RESEND;
            end
          end else if (st.phase == sawarq_pkg::PH_SEG) begin
            if (item.rx_flags == sawarq_pkg::KIND_ACK && item.rx_ack == seq_plus_len) begin
              st_nxt.send_seq = seq_plus_len;
              st_nxt.phase    = sawarq_pkg::PH_CONN;
              act             = sawarq_pkg::ACT_SEG_DONE;
            end else begin
              act = sawarq_pkg::ACT_RESEND;
            end
          end else if (item.rx_flags == sawarq_pkg::KIND_FIN && item.rx_ack == seq_plus1) begin
            st_nxt.phase = sawarq_pkg::PH_CLOSED;
            act          = sawarq_pkg::ACT_FIN_ACKS;
          end
        end
      end
      sawarq_pkg::CMD_TIMEOUT: begin
        if (waiting) begin
          st_nxt.timeout = tmo_dbl;
          if (tmo_dbl > {1'b0, cfg.timeout_limit}) begin
            st_nxt.phase = sawarq_pkg::PH_ABORT;
          end
          act = sawarq_pkg::ACT_RESEND;
        end
      end
      sawarq_pkg::CMD_RX_ERR: begin
        if (waiting) begin
          st_nxt.phase = sawarq_pkg::PH_ABORT;
        end
      end
      default: begin
      end
    endcase
  end

  // The status of a quiet or resend result follows the phase the event leaves.
  assign quiet_status = (st_nxt.phase == sawarq_pkg::PH_ABORT)  ? sawarq_pkg::ST_ABORTED :
                        (st_nxt.phase == sawarq_pkg::PH_CLOSED) ? sawarq_pkg::ST_CLOSED :
                        sawarq_pkg::ST_WAITING;

  // Result word for the chosen action.
  always_comb begin
    res             = '0;
    res.timeout_now = st_nxt.timeout;
    res.last        = 1'b1;
    rep             = 2'd0;
    unique case (act)
      sawarq_pkg::ACT_QUIET: begin
        res.status = quiet_status;
      end
      sawarq_pkg::ACT_RESEND: begin
        res.tx_valid = 1'b1;
        res.tx_kind  = st_nxt.pend_kind;
        res.tx_seq   = st_nxt.send_seq;
        if (st_nxt.pend_kind == sawarq_pkg::KIND_ACK) begin
          res.tx_length = st_nxt.pend_len;
          res.tx_marker = st_nxt.pend_marker;
        end
        res.status = quiet_status;
      end
      sawarq_pkg::ACT_HS_ACK: begin
        res.tx_valid = 1'b1;
        res.tx_kind  = sawarq_pkg::KIND_ACK;
        res.tx_seq   = st_nxt.send_seq;
        res.tx_ack   = peer_ack;
        res.status   = sawarq_pkg::ST_CONNECTED;
      end
      sawarq_pkg::ACT_SEG_DONE: begin
        res.status = sawarq_pkg::ST_SEG_ACKED;
      end
      sawarq_pkg::ACT_FIN_ACKS: begin
        res.tx_valid = 1'b1;
        res.tx_kind  = sawarq_pkg::KIND_ACK;
        res.tx_seq   = st_nxt.send_seq;
        res.tx_ack   = peer_ack;
        res.status   = sawarq_pkg::ST_CLOSED;
        rep          = 2'd2;
      end
      default: begin
        res.status = quiet_status;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/stop_and_wait_arq_sender.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender: sender side of a stop-and-wait link
// Takes connection events and gives the packets to transmit, with a receive
// timeout that doubles on each expiry and halves on receives at or above the floor.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Word
//  in_      input      in_valid/in_ready    sawarq_pkg::in_item_t
//  out_     output     out_valid/out_ready  sawarq_pkg::out_item_t
//  cfg_     input      cfg_we               cfg_index, cfg_wdata (16 bits)
//
//  An event word is taken into an input register and decoded from there into the
//  result register once that is free, so a word follows a word in every cycle
//  while the output is not stalled; the result register drives the output.
//  A peer close answered with three ACKs holds the result register until three
//  words have been taken; every other event gives one result word.
//  Reset sets the link idle, the sequence to zero and the timeout to five.
//  A stalled output holds the result; the input register still takes a word while empty.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_and_wait_arq_sender #(
  parameter int unsigned SEG_BYTES = 1024
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire sawarq_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output sawarq_pkg::out_item_t      out_data,
  input  wire                        cfg_we,
  input  wire [1:0]                  cfg_index,
  input  wire [15:0]                 cfg_wdata
);

  sawarq_pkg::in_item_t    in_r;
  logic                    in_v_r;
  sawarq_pkg::conn_state_t st_r;
  sawarq_pkg::conn_state_t st_nxt;
  sawarq_pkg::cfg_regs_t   cfg_r;
  sawarq_pkg::out_item_t   res_r;
  sawarq_pkg::out_item_t   res_nxt;
  logic                    out_v_r;
  logic [1:0]              rep_r;
  logic [1:0]              rep_nxt;
  logic                    out_free;
  logic                    fire_proc;
  logic                    in_fire;
  logic                    out_fire;

  assign out_fire  = out_v_r && out_ready;
  assign out_free  = !out_v_r || (out_ready && rep_r == 2'd0);
  assign fire_proc = in_v_r && out_free;
  assign in_ready  = !in_v_r || fire_proc;
  assign in_fire   = in_valid && in_ready;

  sawarq_step #(
    .SEG_BYTES(SEG_BYTES)
  ) u_step (
    .item  (in_r),
    .st    (st_r),
    .cfg   (cfg_r),
    .st_nxt(st_nxt),
    .res   (res_nxt),
    .rep   (rep_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (fire_proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_timeout <= sawarq_pkg::INIT_TIMEOUT_RST;
      cfg_r.timeout_limit   <= sawarq_pkg::TIMEOUT_LIM_RST;
      cfg_r.shrink_floor    <= sawarq_pkg::SHRINK_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sawarq_pkg::REG_INIT_TIMEOUT: cfg_r.initial_timeout <= cfg_wdata;
        sawarq_pkg::REG_TIMEOUT_LIM:  cfg_r.timeout_limit   <= cfg_wdata;
        sawarq_pkg::REG_SHRINK_FLOOR: cfg_r.shrink_floor    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= sawarq_pkg::PH_IDLE;
      st_r.send_seq    <= 32'd0;
      st_r.pend_len    <= 11'd0;
      st_r.pend_marker <= sawarq_pkg::MARK_BEGIN;
      st_r.first_done  <= 1'b0;
      st_r.timeout     <= {1'b0, sawarq_pkg::INIT_TIMEOUT_RST};
      st_r.pend_kind   <= sawarq_pkg::KIND_SYN;
    end else if (fire_proc) begin
      st_r <= st_nxt;
    end else if (cfg_we && cfg_index == sawarq_pkg::REG_INIT_TIMEOUT &&
                 st_r.phase == sawarq_pkg::PH_IDLE) begin
      // Before the link opens, a new initial timeout takes effect at once.
      st_r.timeout <= {1'b0, cfg_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (fire_proc) begin
      res_r <= res_nxt;
    end
    if (!rst_n) begin
      out_v_r <= 1'b0;
      rep_r   <= 2'd0;
    end else if (fire_proc) begin
      out_v_r <= 1'b1;
      rep_r   <= rep_nxt;
    end else if (out_fire) begin
      if (rep_r != 2'd0) begin
        rep_r <= rep_r - 2'd1;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_data      = res_r;
    out_data.last = (rep_r == 2'd0);
  end
  assign out_valid = out_v_r;

  // Repeat copies only exist behind a valid result word.
  a_rep_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r != 2'd0 |-> out_v_r)
    else $error("repeat count set with no result word held");

  // Each taken copy of a repeated word counts down and keeps the word on offer.
  a_rep_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && rep_r != 2'd0 |=> out_v_r && rep_r == $past(rep_r) - 2'd1)
    else $error("repeated result word lost or miscounted");

  // An event waiting behind a busy result register is held untouched.
  a_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !fire_proc |=> in_v_r && $stable(in_r))
    else $error("pending event word dropped or changed");

  // An aborted link never leaves the aborted phase.
  a_abort_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == sawarq_pkg::PH_ABORT |=> st_r.phase == sawarq_pkg::PH_ABORT)
    else $error("link left the aborted phase");

  // A closed link stays closed.
  a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == sawarq_pkg::PH_CLOSED |=> st_r.phase == sawarq_pkg::PH_CLOSED)
    else $error("link left the closed phase");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stop-and-wait ARQ sender
// One connection is taken through its whole life: ignored events while idle,
// the handshake, many data segments with lost and wrong answers mixed in, and
// then a close, a receive error or a timeout abort. Every accepted event word
// is run through a behavioural copy of the sender, and each result word is
// compared field by field with the oldest prediction. Both channels idle at
// random, and the registers are rewritten between stages while all is quiet.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned SEG_BYTES   = 1024;
  localparam int unsigned HOLD_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Command codes with no meaning, which the sender must ignore
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  sawarq_pkg::in_item_t   in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sawarq_pkg::out_item_t  out_data;
  logic                   cfg_we    = 1'b0;
  logic [1:0]             cfg_index = '0;
  logic [15:0]            cfg_wdata = '0;

  sawarq_pkg::in_item_t    event_q[$];
  sawarq_pkg::out_item_t   expected_q[$];
  sawarq_pkg::conn_state_t link_st;
  sawarq_pkg::conn_state_t plan_st;
  sawarq_pkg::cfg_regs_t   regs;
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 59;
  int unsigned queued      = 0;
  int unsigned fails       = 0;
  int unsigned cycles      = 0;

  stop_and_wait_arq_sender #(.SEG_BYTES(SEG_BYTES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic sawarq_pkg::out_item_t pending_packet(input sawarq_pkg::conn_state_t st,
                                                           input logic [2:0] stat);
    sawarq_pkg::out_item_t p;
    p          = '0;
    p.tx_valid = 1'b1;
    p.tx_kind  = st.pend_kind;
    p.tx_seq   = st.send_seq;
    if (st.pend_kind == sawarq_pkg::KIND_ACK) begin
      p.tx_length = st.pend_len;
      p.tx_marker = st.pend_marker;
    end
    p.status = stat;
    p.last   = 1'b1;
    return p;
  endfunction

  // Advances the connection by one event and gives the words it sends.
  function automatic void predict_event(input sawarq_pkg::in_item_t ev,
                                        inout sawarq_pkg::conn_state_t st,
                                        input sawarq_pkg::cfg_regs_t cr,
                                        output sawarq_pkg::out_item_t [2:0] pkt,
                                        output int unsigned npkt);
    logic [10:0]           len;
    logic [31:0]           a;
    logic                  waiting;
    sawarq_pkg::out_item_t quiet;
    quiet      = '0;
    quiet.last = 1'b1;
    pkt        = {quiet, quiet, quiet};
    npkt       = 1;
    waiting    = st.phase inside {sawarq_pkg::PH_SYN, sawarq_pkg::PH_SEG, sawarq_pkg::PH_FIN};
    if (ev.cmd == sawarq_pkg::CMD_OPEN && st.phase == sawarq_pkg::PH_IDLE) begin
      st.send_seq    = '0;
      st.pend_kind   = sawarq_pkg::KIND_SYN;
      st.pend_len    = '0;
      st.pend_marker = sawarq_pkg::MARK_BEGIN;
      st.phase       = sawarq_pkg::PH_SYN;
      pkt[0]         = pending_packet(st, sawarq_pkg::ST_WAITING);
    end else if (ev.cmd == sawarq_pkg::CMD_DATA && st.phase == sawarq_pkg::PH_CONN) begin
      len = (ev.seg_length > SEG_BYTES) ? 11'(SEG_BYTES) : ev.seg_length;
      if (!st.first_done) st.send_seq = '0;
      // An end mark takes precedence over a begin mark on a one-segment file.
      st.pend_marker = ev.seg_last ? sawarq_pkg::MARK_END :
                       (st.first_done ? sawarq_pkg::MARK_MIDDLE : sawarq_pkg::MARK_BEGIN);
      st.first_done  = 1'b1;
      st.pend_len    = len;
      st.pend_kind   = sawarq_pkg::KIND_ACK;
      st.phase       = sawarq_pkg::PH_SEG;
      pkt[0]         = pending_packet(st, sawarq_pkg::ST_WAITING);
    end else if (ev.cmd == sawarq_pkg::CMD_CLOSE && st.phase == sawarq_pkg::PH_CONN) begin
      st.send_seq    = '0;
      st.pend_kind   = sawarq_pkg::KIND_FIN;
      st.pend_len    = '0;
      st.pend_marker = sawarq_pkg::MARK_BEGIN;
      st.phase       = sawarq_pkg::PH_FIN;
      pkt[0]         = pending_packet(st, sawarq_pkg::ST_WAITING);
    end else if (ev.cmd == sawarq_pkg::CMD_RX && waiting) begin
      if (st.timeout >= cr.shrink_floor) st.timeout = st.timeout >> 1;
      if (st.phase == sawarq_pkg::PH_SYN) begin
        a = st.send_seq + 32'd1;
        if (ev.rx_ack == a) begin
          st.send_seq      = a;
          st.phase         = sawarq_pkg::PH_CONN;
          pkt[0].tx_valid  = 1'b1;
          pkt[0].tx_kind   = sawarq_pkg::KIND_ACK;
          pkt[0].tx_seq    = a;
          pkt[0].tx_ack    = ev.rx_seq + 32'd1;
          pkt[0].status    = sawarq_pkg::ST_CONNECTED;
        end else begin
          pkt[0] = pending_packet(st, sawarq_pkg::ST_WAITING);
        end
      end else if (st.phase == sawarq_pkg::PH_SEG) begin
        a = st.send_seq + 32'(st.pend_len) + 32'd1;
        if (ev.rx_flags == sawarq_pkg::KIND_ACK && ev.rx_ack == a) begin
          st.send_seq   = a;
          st.phase      = sawarq_pkg::PH_CONN;
          pkt[0].status = sawarq_pkg::ST_SEG_ACKED;
        end else begin
          pkt[0] = pending_packet(st, sawarq_pkg::ST_WAITING);
        end
      end else begin
        a = st.send_seq + 32'd1;
        if (ev.rx_flags == sawarq_pkg::KIND_FIN && ev.rx_ack == a) begin
          st.phase = sawarq_pkg::PH_CLOSED;
          npkt     = 3;
          for (int k = 0; k < 3; k++) begin
            pkt[k].tx_valid = 1'b1;
            pkt[k].tx_kind  = sawarq_pkg::KIND_ACK;
            pkt[k].tx_seq   = st.send_seq;
            pkt[k].tx_ack   = ev.rx_seq + 32'd1;
            pkt[k].status   = sawarq_pkg::ST_CLOSED;
            pkt[k].last     = (k == 2);
          end
        end else begin
          pkt[0].status = sawarq_pkg::ST_WAITING;
        end
      end
    end else if (ev.cmd == sawarq_pkg::CMD_TIMEOUT && waiting) begin
      st.timeout = {st.timeout[15:0], 1'b0};
      if (st.timeout > cr.timeout_limit) begin
        st.phase = sawarq_pkg::PH_ABORT;
        pkt[0]   = pending_packet(st, sawarq_pkg::ST_ABORTED);
      end else begin
        pkt[0] = pending_packet(st, sawarq_pkg::ST_WAITING);
      end
    end else if (ev.cmd == sawarq_pkg::CMD_RX_ERR && waiting) begin
      st.phase      = sawarq_pkg::PH_ABORT;
      pkt[0].status = sawarq_pkg::ST_ABORTED;
    end else begin
      pkt[0].status = (st.phase == sawarq_pkg::PH_ABORT)  ? sawarq_pkg::ST_ABORTED :
                      (st.phase == sawarq_pkg::PH_CLOSED) ? sawarq_pkg::ST_CLOSED :
                      sawarq_pkg::ST_WAITING;
    end
    for (int k = 0; k < 3; k++) pkt[k].timeout_now = st.timeout;
  endfunction

  function automatic sawarq_pkg::in_item_t make_event(input logic [2:0] cmd,
                                                      input logic [10:0] len,
                                                      input logic last,
                                                      input logic [1:0] flags,
                                                      input logic [31:0] seq,
                                                      input logic [31:0] ack);
    sawarq_pkg::in_item_t ev;
    ev.cmd        = cmd;
    ev.seg_length = len;
    ev.seg_last   = last;
    ev.rx_flags   = flags;
    ev.rx_seq     = seq;
    ev.rx_ack     = ack;
    return ev;
  endfunction

  function automatic sawarq_pkg::in_item_t random_event();
    return make_event(3'($urandom_range(0, 7)), 11'($urandom_range(0, 2047)),
                      1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      $urandom(), $urandom());
  endfunction

  // The acknowledgement that the peer must send next to move the link on.
  function automatic logic [31:0] next_ack();
    if (plan_st.phase == sawarq_pkg::PH_SEG)
      return plan_st.send_seq + 32'(plan_st.pend_len) + 32'd1;
    return plan_st.send_seq + 32'd1;
  endfunction

  task automatic queue_event(input sawarq_pkg::in_item_t ev);
    sawarq_pkg::out_item_t [2:0] pk;
    int unsigned                 n;
    predict_event(ev, plan_st, regs, pk, n);
    event_q.push_back(ev);
    queued++;
  endtask

  // A stray word that leaves the connection alive: wrong answers, timeouts
  // below the limit and commands out of place.
  task automatic queue_noise();
    sawarq_pkg::in_item_t        ev;
    sawarq_pkg::conn_state_t     trial;
    sawarq_pkg::out_item_t [2:0] pk;
    int unsigned                 n;
    do begin
      ev = random_event();
      if ($urandom_range(0, 1)) ev.rx_ack = next_ack() ^ (32'd1 << $urandom_range(0, 31));
      trial = plan_st;
      predict_event(ev, trial, regs, pk, n);
    end while (trial.phase inside {sawarq_pkg::PH_FIN, sawarq_pkg::PH_CLOSED,
                                   sawarq_pkg::PH_ABORT});
    queue_event(ev);
  endtask

  task automatic queue_segment();
    sawarq_pkg::in_item_t ev;
    ev     = random_event();
    ev.cmd = sawarq_pkg::CMD_DATA;
    queue_event(ev);
    repeat ($urandom_range(0, 2)) queue_noise();
    if (plan_st.phase == sawarq_pkg::PH_SEG) begin
      ev          = random_event();
      ev.cmd      = sawarq_pkg::CMD_RX;
      ev.rx_flags = sawarq_pkg::KIND_ACK;
      ev.rx_ack   = next_ack();
      queue_event(ev);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = queued + count;
    while (queued < target) begin
      if ($urandom_range(0, 3) != 0) queue_segment();
      else queue_noise();
    end
  endtask

  // Sampled on the falling edge so that the driver's pops cannot race it.
  task automatic drain();
    @(negedge clk);
    while (event_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sawarq_pkg::REG_INIT_TIMEOUT: begin
        regs.initial_timeout = val;
        if (link_st.phase == sawarq_pkg::PH_IDLE) begin
          link_st.timeout = 17'(val);
          plan_st.timeout = 17'(val);
        end
      end
      sawarq_pkg::REG_TIMEOUT_LIM: begin
        regs.timeout_limit = val;
      end
      sawarq_pkg::REG_SHRINK_FLOOR: begin
        regs.shrink_floor = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic compare_word(input sawarq_pkg::out_item_t want,
                              input sawarq_pkg::out_item_t got);
    check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
    check_field("tx_kind", 32'(want.tx_kind), 32'(got.tx_kind));
    check_field("tx_seq", want.tx_seq, got.tx_seq);
    check_field("tx_ack", want.tx_ack, got.tx_ack);
    check_field("tx_length", 32'(want.tx_length), 32'(got.tx_length));
    check_field("tx_marker", 32'(want.tx_marker), 32'(got.tx_marker));
    check_field("timeout_now", 32'(want.timeout_now), 32'(got.timeout_now));
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("last", 32'(want.last), 32'(got.last));
  endtask

  // Event driver: predicts on acceptance, then offers the next queued word.
  always @(posedge clk) begin
    sawarq_pkg::out_item_t [2:0] pkts;
    int unsigned                 n;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_event(in_data, link_st, regs, pkts, n);
        for (int k = 0; k < n; k++) expected_q.push_back(pkts[k]);
      end
      if (!in_valid || in_ready) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, out_data);
          fails++;
        end else begin
          compare_word(expected_q.pop_front(), out_data);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** stop_and_wait_arq_sender: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    link_st         = '0;
    link_st.phase   = sawarq_pkg::PH_IDLE;
    link_st.timeout = 17'(sawarq_pkg::INIT_TIMEOUT_RST);
    plan_st         = link_st;
    regs            = {sawarq_pkg::INIT_TIMEOUT_RST, sawarq_pkg::TIMEOUT_LIM_RST,
                       sawarq_pkg::SHRINK_FLOOR_RST};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(sawarq_pkg::REG_INIT_TIMEOUT, 16'hFFFF);
    write_reg(sawarq_pkg::REG_TIMEOUT_LIM, 16'hFFFF);
    write_reg(sawarq_pkg::REG_SHRINK_FLOOR, 16'hFFFF);

    // Everything but open is ignored while idle.
    queue_event(make_event(sawarq_pkg::CMD_DATA, 11'h7FF, 1'b1, 2'd3, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, '0, 32'd1));
    queue_event(make_event(sawarq_pkg::CMD_TIMEOUT, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_CLOSE, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX_ERR, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(CMD_SPARE6, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(CMD_SPARE7, 11'h7FF, 1'b1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();
    write_reg(sawarq_pkg::REG_INIT_TIMEOUT, 16'd1);
    write_reg(sawarq_pkg::REG_SHRINK_FLOOR, 16'd2);

    // Handshake with a wrong answer and a lost one; the peer's sequence wraps.
    queue_event(make_event(sawarq_pkg::CMD_OPEN, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK,
                           32'h1234_5678, '0));
    queue_event(make_event(sawarq_pkg::CMD_TIMEOUT, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_SYN,
                           32'hFFFF_FFFF, next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_OPEN, 11'h7FF, 1'b1, 2'd3, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, '0,
                           next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_TIMEOUT, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    // The first segment is either a whole file or the start of one.
    queue_event(make_event(sawarq_pkg::CMD_DATA, '0, 1'($urandom_range(0, 1)),
                           sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_SYN, '0,
                           next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, '0,
                           next_ack() + 32'd1));
    queue_event(make_event(sawarq_pkg::CMD_TIMEOUT, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK,
                           32'hFFFF_FFFF, next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_DATA, 11'h7FF, 1'b0, sawarq_pkg::KIND_SYN,
                           '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_CLOSE, '0, 1'b0, sawarq_pkg::KIND_SYN, '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_FIN, '0,
                           next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, '0,
                           next_ack()));
    queue_event(make_event(sawarq_pkg::CMD_DATA, 11'd1024, 1'b1, sawarq_pkg::KIND_SYN,
                           '0, '0));
    queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, '0,
                           next_ack()));

    drain();
    write_reg(sawarq_pkg::REG_TIMEOUT_LIM, 16'd100);
    write_reg(sawarq_pkg::REG_SHRINK_FLOOR, 16'd8);
    run_random(35);

    // Halving is disabled here, so the timeout only climbs towards the limit.
    drain();
    tx_idle_pct = 59;
    rx_idle_pct = 15;
    write_reg(sawarq_pkg::REG_TIMEOUT_LIM, 16'hFFFF);
    write_reg(sawarq_pkg::REG_SHRINK_FLOOR, 16'hFFFF);
    run_random(35);

    // A floor of one lets the timeout halve all the way down to zero.
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(sawarq_pkg::REG_INIT_TIMEOUT, 16'd40000);
    write_reg(sawarq_pkg::REG_TIMEOUT_LIM, 16'd1000);
    write_reg(sawarq_pkg::REG_SHRINK_FLOOR, 16'd1);
    run_random(40);

    drain();
    write_reg(sawarq_pkg::REG_TIMEOUT_LIM, 16'd1);
    if (plan_st.phase == sawarq_pkg::PH_SEG)
      queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK, $urandom(),
                             next_ack()));
    case ($urandom_range(0, 2))
      0: begin
        queue_event(make_event(sawarq_pkg::CMD_CLOSE, '0, 1'b0, sawarq_pkg::KIND_SYN,
                               '0, '0));
        queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_FIN,
                               $urandom(), next_ack() + 32'd1));
        queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_ACK,
                               $urandom(), next_ack()));
        queue_event(make_event(sawarq_pkg::CMD_RX, '0, 1'b0, sawarq_pkg::KIND_FIN,
                               $urandom(), next_ack()));
      end
      1: begin
        queue_event(make_event(sawarq_pkg::CMD_DATA, 11'($urandom_range(0, 2047)), 1'b0,
                               sawarq_pkg::KIND_SYN, '0, '0));
        queue_event(make_event(sawarq_pkg::CMD_RX_ERR, '0, 1'b0, sawarq_pkg::KIND_SYN,
                               $urandom(), $urandom()));
      end
      default: begin
        queue_event(make_event(sawarq_pkg::CMD_DATA, 11'($urandom_range(0, 2047)), 1'b1,
                               sawarq_pkg::KIND_SYN, '0, '0));
        // A timeout already at zero never passes the limit, so fall back to an error.
        k = 0;
        while (k < 18 && plan_st.phase == sawarq_pkg::PH_SEG) begin
          queue_event(make_event(sawarq_pkg::CMD_TIMEOUT, '0, 1'b0, sawarq_pkg::KIND_SYN,
                                 '0, '0));
          k++;
        end
        if (plan_st.phase == sawarq_pkg::PH_SEG)
          queue_event(make_event(sawarq_pkg::CMD_RX_ERR, '0, 1'b0, sawarq_pkg::KIND_SYN,
                                 '0, '0));
      end
    endcase
    // Once closed or aborted, every word is ignored.
    repeat (5) queue_event(random_event());

    drain();
    if (fails == 0 && expected_q.size() == 0) begin
      $display("** stop_and_wait_arq_sender: PASSED **");
    end else begin
      $display("** stop_and_wait_arq_sender: FAILED **");
    end
    $finish;
  end

endmodule
